// File: hw/rtl/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared constants, payload structs and controller/datapath interface types
// for the window page mapper.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int unsigned WINDOW_COUNT = 4;
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned ADDRESS_BITS = 24;

  // request / result field widths
  localparam int unsigned REQ_ADDR_BITS = 24;
  localparam int unsigned REQ_LEN_BITS  = 24;
  localparam int unsigned WIN_NUM_BITS  = 3;
  localparam int unsigned WIN_OFS_BITS  = 12;
  localparam int unsigned GRANT_BITS    = 15;

  localparam int unsigned OFFSET_BITS = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_BITS   = ADDRESS_BITS - OFFSET_BITS;
  localparam int unsigned END_BITS    = PAGE_BITS + 1;
  localparam int unsigned STOP_BITS   = ADDRESS_BITS + 1;
  localparam int unsigned SUM_BITS    =
    ((ADDRESS_BITS > REQ_LEN_BITS) ? ADDRESS_BITS : REQ_LEN_BITS) + 1;
  localparam int unsigned IDX_BITS    = $clog2(WINDOW_COUNT);
  localparam int unsigned USES_BITS   = 16;

  typedef struct packed {
    logic [REQ_ADDR_BITS-1:0] request_address;
    logic [REQ_LEN_BITS-1:0]  request_length;
  } req_t;

  typedef struct packed {
    logic                    mapped;
    logic [WIN_NUM_BITS-1:0] window_number;
    logic [WIN_OFS_BITS-1:0] window_offset;
    logic [GRANT_BITS-1:0]   granted_length;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_ROUND,
    ST_CLAMP,
    ST_PAGE,
    ST_SCAN,
    ST_PICK,
    ST_SHIFT,
    ST_AGE,
    ST_COUNT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch;      // capture request
    logic range;      // clamp address + length to top of space
    logic round;      // round stop up to page boundary
    logic clamp;      // limit range to WINDOW_COUNT pages, start page cursor
    logic scan_init;  // restart slot scan for current page
    logic scan_step;  // examine one slot
    logic next_page;  // page present or no victim: skip to next page
    logic pick;       // load shift cursor from victim
    logic move;       // shift one neighbor into cursor slot
    logic place;      // write current page into cursor slot
    logic age;        // age counts by victim count, advance page
    logic count;      // bump counts below range end, form result
  } ctrl_cmd_t;

  typedef struct packed {
    logic page_left;
    logic scan_hit;
    logic scan_last;
    logic victim_found;
    logic shift_more;
  } dp_status_t;

endpackage

// File: hw/rtl/wpm_ctrl.sv
// ----------------------------------------------------------------------------
// wpm_ctrl
// Sequencer for the window page mapper: walks each request through range
// setup, per-page scan / insert / age, and the final count update.
// ----------------------------------------------------------------------------
module wpm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  wpm_pkg::dp_status_t  status_i,
  output wpm_pkg::ctrl_cmd_t   cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import wpm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_RANGE;
        end
      end
      ST_RANGE: begin
        cmd_o.range = 1'b1;
        state_d     = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = ST_PAGE;
      end
      ST_PAGE: begin
        if (status_i.page_left) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          state_d = ST_COUNT;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_hit) begin
          cmd_o.next_page = 1'b1;
          state_d         = ST_PAGE;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (status_i.scan_last) begin
            state_d = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        if (status_i.victim_found) begin
          cmd_o.pick = 1'b1;
          state_d    = ST_SHIFT;
        end else begin
          cmd_o.next_page = 1'b1;
          state_d         = ST_PAGE;
        end
      end
      ST_SHIFT: begin
        if (status_i.shift_more) begin
          cmd_o.move = 1'b1;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = ST_AGE;
        end
      end
      ST_AGE: begin
        cmd_o.age = 1'b1;
        state_d   = ST_PAGE;
      end
      ST_COUNT: begin
        cmd_o.count = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        busy_o = 1'b0;
        done_o = 1'b1;
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_RANGE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/wpm_datapath.sv
// ----------------------------------------------------------------------------
// wpm_datapath
// Window table (page numbers and use counts), range registers, scan and
// shift cursors, and the result register.
// ----------------------------------------------------------------------------
module wpm_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wpm_pkg::req_t        request_i,
  input  wpm_pkg::ctrl_cmd_t   cmd_i,
  output wpm_pkg::dp_status_t  status_o,
  output wpm_pkg::rsp_t        result_o
);
  import wpm_pkg::*;

  localparam logic [IDX_BITS-1:0] LastIdx = IDX_BITS'(WINDOW_COUNT - 1);
  localparam logic [SUM_BITS-1:0] TopSum  = SUM_BITS'(1) << ADDRESS_BITS;

  // window table
  logic [PAGE_BITS-1:0] page_q [WINDOW_COUNT];
  logic [USES_BITS-1:0] uses_q [WINDOW_COUNT];

  // request / range registers
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [REQ_LEN_BITS-1:0] len_q;
  logic [STOP_BITS-1:0]    stop_q;
  logic [END_BITS-1:0]     ep_q;
  logic [END_BITS-1:0]     cur_q;
  logic [GRANT_BITS-1:0]   granted_q;

  // scan / shift state
  logic [IDX_BITS-1:0]  idx_q;
  logic [IDX_BITS-1:0]  victim_q;
  logic                 vic_valid_q;
  logic [USES_BITS-1:0] least_q;
  logic                 up_q;

  rsp_t rsp_q;

  logic [END_BITS-1:0]  sp;
  logic [SUM_BITS-1:0]  sum;
  logic [STOP_BITS-1:0] rnd;
  logic [END_BITS-1:0]  span;
  logic [STOP_BITS-1:0] end_byte;
  logic [STOP_BITS-1:0] grant_full;

  logic [PAGE_BITS-1:0] scan_page;
  logic [USES_BITS-1:0] scan_uses;
  logic                 scan_out;

  logic [WINDOW_COUNT-1:0] le_vec, ge_vec, lt_ep, act;
  logic [WINDOW_COUNT-1:0] sel;
  logic [IDX_BITS-1:0]     idx_inc, idx_dec;

  logic [PAGE_BITS-1:0] up_page [WINDOW_COUNT];
  logic [PAGE_BITS-1:0] dn_page [WINDOW_COUNT];
  logic [USES_BITS-1:0] up_uses [WINDOW_COUNT];
  logic [USES_BITS-1:0] dn_uses [WINDOW_COUNT];

  logic                found;
  logic [IDX_BITS-1:0] where_idx;

  assign sp         = END_BITS'(addr_q[ADDRESS_BITS-1:OFFSET_BITS]);
  assign sum        = SUM_BITS'(addr_q) + SUM_BITS'(len_q);
  assign rnd        = stop_q + STOP_BITS'(PAGE_BYTES - 1);
  assign span       = ep_q - sp;
  assign end_byte   = {ep_q, {OFFSET_BITS{1'b0}}};
  assign grant_full = end_byte - STOP_BITS'(addr_q);

  assign idx_inc = idx_q + 1'b1;
  assign idx_dec = idx_q - 1'b1;

  // single read port for the slot scan
  assign scan_page = page_q[idx_q];
  assign scan_uses = uses_q[idx_q];
  assign scan_out  = (END_BITS'(scan_page) < sp) || (END_BITS'(scan_page) >= ep_q);

  // per-slot compares against the current page and range end
  always_comb begin
    for (int j = 0; j < WINDOW_COUNT; j++) begin
      le_vec[j] = END_BITS'(page_q[j]) <= cur_q;
      ge_vec[j] = END_BITS'(page_q[j]) >= cur_q;
      lt_ep[j]  = END_BITS'(page_q[j]) <  ep_q;
      sel[j]    = idx_q == IDX_BITS'(j);
    end
  end

  // counting stops at the first slot at or above the range end
  always_comb begin
    act[0]    = lt_ep[0];
    found     = 1'b0;
    where_idx = '0;
    for (int j = 1; j < WINDOW_COUNT; j++) begin
      act[j] = act[j-1] & lt_ep[j];
    end
    for (int j = 0; j < WINDOW_COUNT; j++) begin
      if (act[j] && (END_BITS'(page_q[j]) == sp)) begin
        found     = 1'b1;
        where_idx = IDX_BITS'(j);
      end
    end
  end

  always_comb begin
    status_o              = '0;
    status_o.page_left    = cur_q < ep_q;
    status_o.scan_hit     = END_BITS'(scan_page) == cur_q;
    status_o.scan_last    = idx_q == LastIdx;
    status_o.victim_found = vic_valid_q;
    if (up_q) begin
      status_o.shift_more = (idx_q != LastIdx) && le_vec[idx_inc];
    end else begin
      status_o.shift_more = (idx_q != '0) && ge_vec[idx_dec];
    end
  end

  // neighbor taps for the insertion shift
  for (genvar j = 0; j < WINDOW_COUNT; j++) begin : g_tap
    if (j < WINDOW_COUNT - 1) begin : g_up
      assign up_page[j] = page_q[j+1];
      assign up_uses[j] = uses_q[j+1];
    end else begin : g_up_edge
      assign up_page[j] = page_q[j];
      assign up_uses[j] = uses_q[j];
    end
    if (j > 0) begin : g_dn
      assign dn_page[j] = page_q[j-1];
      assign dn_uses[j] = uses_q[j-1];
    end else begin : g_dn_edge
      assign dn_page[j] = page_q[j];
      assign dn_uses[j] = uses_q[j];
    end
  end

  for (genvar j = 0; j < WINDOW_COUNT; j++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        page_q[j] <= PAGE_BITS'(j);
        uses_q[j] <= '0;
      end else begin
        priority if (cmd_i.move && sel[j]) begin
          page_q[j] <= up_q ? up_page[j] : dn_page[j];
          uses_q[j] <= up_q ? up_uses[j] : dn_uses[j];
        end else if (cmd_i.place && sel[j]) begin
          page_q[j] <= PAGE_BITS'(cur_q);
        end else if (cmd_i.age) begin
          uses_q[j] <= (uses_q[j] >= least_q) ? (uses_q[j] - least_q) : '0;
        end else if (cmd_i.count && act[j] && (uses_q[j] != '1)) begin
          uses_q[j] <= uses_q[j] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vic_valid_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      vic_valid_q <= 1'b0;
    end else if (cmd_i.scan_step && scan_out) begin
      vic_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    granted_q <= GRANT_BITS'(grant_full);
    if (cmd_i.latch) begin
      addr_q <= ADDRESS_BITS'(request_i.request_address);
      len_q  <= request_i.request_length;
    end
    if (cmd_i.range) begin
      stop_q <= STOP_BITS'((sum > TopSum) ? TopSum : sum);
    end
    if (cmd_i.round) begin
      ep_q <= rnd[STOP_BITS-1:OFFSET_BITS];
    end
    if (cmd_i.clamp) begin
      if (span > END_BITS'(WINDOW_COUNT)) begin
        ep_q <= sp + END_BITS'(WINDOW_COUNT);
      end
      cur_q <= sp;
    end
    if (cmd_i.next_page || cmd_i.age) begin
      cur_q <= cur_q + 1'b1;
    end
    if (cmd_i.scan_init) begin
      idx_q <= '0;
    end
    if (cmd_i.scan_step) begin
      idx_q <= idx_inc;
      // strict compare keeps the first of equal counts
      if (scan_out && (!vic_valid_q || (scan_uses < least_q))) begin
        victim_q <= idx_q;
        least_q  <= scan_uses;
      end
    end
    if (cmd_i.pick) begin
      idx_q <= victim_q;
      up_q  <= ~ge_vec[victim_q];
    end
    if (cmd_i.move) begin
      idx_q <= up_q ? idx_inc : idx_dec;
    end
    if (cmd_i.count) begin
      if (found && (granted_q != '0)) begin
        rsp_q.mapped         <= 1'b1;
        rsp_q.window_number  <= WIN_NUM_BITS'(where_idx) + WIN_NUM_BITS'(1);
        rsp_q.window_offset  <= WIN_OFS_BITS'(addr_q[OFFSET_BITS-1:0]);
        rsp_q.granted_length <= granted_q;
      end else begin
        rsp_q <= '0;
      end
    end
  end

  assign result_o = rsp_q;

endmodule

// File: hw/rtl/window_page_mapper.sv
// ----------------------------------------------------------------------------
// window_page_mapper
// Maps a board memory range into a small sorted table of bus windows,
// evicting the least-used window outside the range for each missing page.
//
//   port        dir  width      role
//   start       in   1          request strobe, taken when busy is low
//   busy        out  1          high while a request is in progress
//   request_i   in   req_t      address and length
//   done_o      out  1          one-cycle result strobe
//   result_o    out  rsp_t      mapped flag, window, offset, granted length
//
// Range setup is followed, per page of the clamped range, by the
// one-slot-per-cycle table scan and the one-step-per-cycle insertion shift.
// A new request is taken in the cycle that done_o is high.
// Reset restores window i to page i with zero use counts; no clearing pass.
// The result cannot be stalled: it is valid only while done_o is high.
// ----------------------------------------------------------------------------
module window_page_mapper (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  wpm_pkg::req_t  request_i,
  output logic           done_o,
  output wpm_pkg::rsp_t  result_o
);
  import wpm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  wpm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  wpm_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .request_i (request_i),
    .cmd_i     (cmd),
    .status_o  (sts),
    .result_o  (result_o)
  );

  a_done_after_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd.count))
    else $error("result strobe without count update");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  a_move_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.move |-> sts.shift_more)
    else $error("shift step past insertion point");

  a_mapped_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.mapped) |-> (result_o.granted_length != '0))
    else $error("mapped result with zero length");

endmodule
